// ----- sv/ptp_pkg.sv -----
// Package for the perspective point transform: widths, codes, reset values
// and the structures that travel between the pipeline sections.
// No dependencies.
package ptp_pkg;

   // Fixed-point format of coefficients, coordinates and results.
   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Port widths fixed by the interface.
   localparam int PORT_W    = 32;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   // Internal widths, all derived from the word format.
   localparam int PROD_W     = 2 * WORD_WIDTH;
   localparam int SHIFT_W    = PROD_W - FRAC_BITS;
   localparam int SUM_W      = SHIFT_W + 2;
   localparam int MAG_W      = SUM_W;
   localparam int NUM_W      = MAG_W + FRAC_BITS;
   localparam int TOP_W      = NUM_W - WORD_WIDTH;
   localparam int CMP_W      = (TOP_W > MAG_W) ? TOP_W : MAG_W;
   localparam int DIV_STAGES = WORD_WIDTH;

   // Most negative word magnitude, the saturation limit for negative results.
   localparam logic [WORD_WIDTH-1:0] HALF_WORD = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   // Register reset values (identity transform, w equal to one).
   localparam logic [CSR_W-1:0] ROW0_RESET = 64'h0001_0000_0000_0000;
   localparam logic [CSR_W-1:0] ROW1_RESET = 64'h0000_0000_0001_0000;
   localparam logic [CSR_W-1:0] ROW3_RESET = 64'h0000_0000_0000_0000;
   localparam logic [CSR_W-1:0] XYOFF_RESET = 64'h0000_0000_0000_0000;
   localparam logic [PORT_W-1:0] WOFF_RESET = 32'h0001_0000;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW0  = 3'd0,
      REG_ROW1  = 3'd1,
      REG_ROW3  = 3'd2,
      REG_XYOFF = 3'd3,
      REG_WOFF  = 3'd4
   } reg_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   // The nine matrix coefficients in use.
   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] m00;
      logic signed [WORD_WIDTH-1:0] m01;
      logic signed [WORD_WIDTH-1:0] m03;
      logic signed [WORD_WIDTH-1:0] m10;
      logic signed [WORD_WIDTH-1:0] m11;
      logic signed [WORD_WIDTH-1:0] m13;
      logic signed [WORD_WIDTH-1:0] m30;
      logic signed [WORD_WIDTH-1:0] m31;
      logic signed [WORD_WIDTH-1:0] m33;
   } coef_type;

   // Transformed point before the divide.
   typedef struct packed {
      logic signed [SUM_W-1:0] nx;
      logic signed [SUM_W-1:0] ny;
      logic signed [SUM_W-1:0] w;
   } sum_type;

   // One word in the divider: shared divisor, per-lane partial remainder,
   // remaining dividend bits, quotient so far and sign/overflow flags.
   typedef struct packed {
      logic [MAG_W-1:0]      ud;
      logic [MAG_W-1:0]      rem_x;
      logic [MAG_W-1:0]      rem_y;
      logic [WORD_WIDTH-1:0] low_x;
      logic [WORD_WIDTH-1:0] low_y;
      logic [WORD_WIDTH-1:0] q_x;
      logic [WORD_WIDTH-1:0] q_y;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ovf_x;
      logic                  ovf_y;
      logic                  zero;
   } div_type;

endpackage

// ----- sv/point_transform_perspective_core.sv -----
// Top level of the perspective point transform: configuration registers and
// the four pipeline sections. Depends on ptp_pkg, ptp_mac, ptp_prep, ptp_div
// and ptp_fin.
//
// Each accepted word is a point (x, y) in signed Q16.16. It is mapped through
// rows 0, 1 and 3 of the configured matrix and x and y are divided by the
// resulting w; quotients saturate to the Q16.16 range (status 2) and a zero
// w gives zero results with status 1. The block takes one point per clock
// while not stalled; a point passes through two multiply-accumulate stages,
// two divide setup stages, one stage per quotient bit in the divider, and
// the result register. Each stage holds its word under a stall and empty
// stages close up, so points keep entering while a result waits. Write the
// matrix only while no point is in flight.
module point_transform_perspective_core
   import ptp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PORT_W-1:0]    req_point_x,
   input  logic [PORT_W-1:0]    req_point_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PORT_W-1:0]    rsp_proj_x,
   output logic [PORT_W-1:0]    rsp_proj_y,
   output logic [1:0]           rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   logic [CSR_W-1:0]  row0_ff, row0_in, row1_ff, row1_in, row3_ff, row3_in;
   logic [CSR_W-1:0]  xyoff_ff, xyoff_in;
   logic [PORT_W-1:0] woff_ff, woff_in;
   coef_type          coef;
   logic              mac_in_ready, mac_v, prep_in_ready, prep_v;
   logic              div_in_ready, div_v, fin_in_ready;
   sum_type           mac_data;
   div_type           prep_data, div_data;
   status_type        status;

   // Configuration writes; indexes beyond the list are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      row0_in  = (csr_valid && csr_index == REG_ROW0) ? csr_data : row0_ff;
      row1_in  = (csr_valid && csr_index == REG_ROW1) ? csr_data : row1_ff;
      row3_in  = (csr_valid && csr_index == REG_ROW3) ? csr_data : row3_ff;
      xyoff_in = (csr_valid && csr_index == REG_XYOFF) ? csr_data : xyoff_ff;
      woff_in  = (csr_valid && csr_index == REG_WOFF) ? csr_data[PORT_W-1:0] : woff_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff  <= ROW0_RESET;
         row1_ff  <= ROW1_RESET;
         row3_ff  <= ROW3_RESET;
         xyoff_ff <= XYOFF_RESET;
         woff_ff  <= WOFF_RESET;
      end else begin
         row0_ff  <= row0_in;
         row1_ff  <= row1_in;
         row3_ff  <= row3_in;
         xyoff_ff <= xyoff_in;
         woff_ff  <= woff_in;
      end
   end

   // Each coefficient is the low word of its 32-bit half.
   always_comb begin
      coef.m00 = signed'(row0_ff[32+WORD_WIDTH-1:32]);
      coef.m01 = signed'(row0_ff[WORD_WIDTH-1:0]);
      coef.m10 = signed'(row1_ff[32+WORD_WIDTH-1:32]);
      coef.m11 = signed'(row1_ff[WORD_WIDTH-1:0]);
      coef.m30 = signed'(row3_ff[32+WORD_WIDTH-1:32]);
      coef.m31 = signed'(row3_ff[WORD_WIDTH-1:0]);
      coef.m03 = signed'(xyoff_ff[32+WORD_WIDTH-1:32]);
      coef.m13 = signed'(xyoff_ff[WORD_WIDTH-1:0]);
      coef.m33 = signed'(woff_ff[WORD_WIDTH-1:0]);
   end

   assign req_stall = !mac_in_ready;

   ptp_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (req_valid),
      .in_x      (signed'(req_point_x[WORD_WIDTH-1:0])),
      .in_y      (signed'(req_point_y[WORD_WIDTH-1:0])),
      .in_ready  (mac_in_ready),
      .out_valid (mac_v),
      .out_data  (mac_data),
      .out_ready (prep_in_ready)
   );

   ptp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mac_v),
      .in_data   (mac_data),
      .in_ready  (prep_in_ready),
      .out_valid (prep_v),
      .out_data  (prep_data),
      .out_ready (div_in_ready)
   );

   ptp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_v),
      .in_data   (prep_data),
      .in_ready  (div_in_ready),
      .out_valid (div_v),
      .out_data  (div_data),
      .out_ready (fin_in_ready)
   );

   ptp_fin u_fin (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_v),
      .in_data    (div_data),
      .in_ready   (fin_in_ready),
      .out_valid  (rsp_valid),
      .out_x      (rsp_proj_x),
      .out_y      (rsp_proj_y),
      .out_status (status),
      .out_ready  (!rsp_stall)
   );

   assign rsp_status = status;

endmodule

// ----- sv/ptp_mac.sv -----
// Multiply-accumulate section: six products in the first stage, floor
// scaling and the three row sums in the second. Depends on ptp_pkg.
module ptp_mac
   import ptp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  coef_type                     coef,
   input  logic                         in_valid,
   input  logic signed [WORD_WIDTH-1:0] in_x,
   input  logic signed [WORD_WIDTH-1:0] in_y,
   output logic                         in_ready,
   output logic                         out_valid,
   output sum_type                      out_data,
   input  logic                         out_ready
);

   typedef struct packed {
      logic signed [PROD_W-1:0] p00;
      logic signed [PROD_W-1:0] p01;
      logic signed [PROD_W-1:0] p10;
      logic signed [PROD_W-1:0] p11;
      logic signed [PROD_W-1:0] p30;
      logic signed [PROD_W-1:0] p31;
   } prod_type;

   logic     s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic     s1_rdy, s2_rdy;
   prod_type s1_ff, s1_in, prod;
   sum_type  s2_ff, s2_in, sums;

   // Floor-scaled product, widened to the sum width.
   function automatic logic signed [SUM_W-1:0] scale(input logic signed [PROD_W-1:0] p);
      logic signed [SHIFT_W-1:0] t;
      t = SHIFT_W'(p >>> FRAC_BITS);
      return SUM_W'(t);
   endfunction

   // A stage takes a new word when it is empty or its successor takes its word.
   always_comb begin
      s2_rdy   = !s2_v_ff || out_ready;
      s1_rdy   = !s1_v_ff || s2_rdy;
      in_ready = s1_rdy;
   end

   // Stage one: the six products.
   always_comb begin
      prod.p00 = coef.m00 * in_x;
      prod.p01 = coef.m01 * in_y;
      prod.p10 = coef.m10 * in_x;
      prod.p11 = coef.m11 * in_y;
      prod.p30 = coef.m30 * in_x;
      prod.p31 = coef.m31 * in_y;
      s1_v_in  = s1_rdy ? in_valid : s1_v_ff;
      s1_in    = (s1_rdy && in_valid) ? prod : s1_ff;
   end

   // Stage two: scaled products plus the constant column.
   always_comb begin
      sums.nx = scale(s1_ff.p00) + scale(s1_ff.p01) + SUM_W'(coef.m03);
      sums.ny = scale(s1_ff.p10) + scale(s1_ff.p11) + SUM_W'(coef.m13);
      sums.w  = scale(s1_ff.p30) + scale(s1_ff.p31) + SUM_W'(coef.m33);
      s2_v_in = s2_rdy ? s1_v_ff : s2_v_ff;
      s2_in   = (s2_rdy && s1_v_ff) ? sums : s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

endmodule

// ----- sv/ptp_prep.sv -----
// Divide preparation: magnitudes, signs and the zero test in one stage,
// overflow test and initial remainders in the next. Depends on ptp_pkg.
module ptp_prep
   import ptp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  sum_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output div_type out_data,
   input  logic    out_ready
);

   typedef struct packed {
      logic [MAG_W-1:0] un_x;
      logic [MAG_W-1:0] un_y;
      logic [MAG_W-1:0] ud;
      logic             neg_x;
      logic             neg_y;
      logic             zero;
   } abs_type;

   logic             s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic             s1_rdy, s2_rdy;
   abs_type          s1_ff, s1_in, mags;
   div_type          s2_ff, s2_in, init;
   logic [NUM_W-1:0] num_x, num_y;
   logic [TOP_W-1:0] top_x, top_y;

   always_comb begin
      s2_rdy   = !s2_v_ff || out_ready;
      s1_rdy   = !s1_v_ff || s2_rdy;
      in_ready = s1_rdy;
   end

   // Stage one: absolute values and the quotient signs.
   always_comb begin
      mags.un_x  = in_data.nx[SUM_W-1] ? MAG_W'(-in_data.nx) : MAG_W'(in_data.nx);
      mags.un_y  = in_data.ny[SUM_W-1] ? MAG_W'(-in_data.ny) : MAG_W'(in_data.ny);
      mags.ud    = in_data.w[SUM_W-1] ? MAG_W'(-in_data.w) : MAG_W'(in_data.w);
      mags.neg_x = in_data.nx[SUM_W-1] ^ in_data.w[SUM_W-1];
      mags.neg_y = in_data.ny[SUM_W-1] ^ in_data.w[SUM_W-1];
      mags.zero  = (in_data.w == '0);
      s1_v_in    = s1_rdy ? in_valid : s1_v_ff;
      s1_in      = (s1_rdy && in_valid) ? mags : s1_ff;
   end

   // Stage two: the dividend is the magnitude scaled by the fraction bits.
   // Its bits above the quotient width form the first remainder; if that
   // already reaches the divisor the quotient needs more than a word.
   always_comb begin
      num_x = {s1_ff.un_x, {FRAC_BITS{1'b0}}};
      num_y = {s1_ff.un_y, {FRAC_BITS{1'b0}}};
      top_x = num_x[NUM_W-1:WORD_WIDTH];
      top_y = num_y[NUM_W-1:WORD_WIDTH];
      init.ud    = s1_ff.ud;
      init.rem_x = MAG_W'(top_x);
      init.rem_y = MAG_W'(top_y);
      init.low_x = num_x[WORD_WIDTH-1:0];
      init.low_y = num_y[WORD_WIDTH-1:0];
      init.q_x   = '0;
      init.q_y   = '0;
      init.neg_x = s1_ff.neg_x;
      init.neg_y = s1_ff.neg_y;
      init.ovf_x = (CMP_W'(top_x) >= CMP_W'(s1_ff.ud));
      init.ovf_y = (CMP_W'(top_y) >= CMP_W'(s1_ff.ud));
      init.zero  = s1_ff.zero;
      s2_v_in    = s2_rdy ? s1_v_ff : s2_v_ff;
      s2_in      = (s2_rdy && s1_v_ff) ? init : s2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

endmodule

// ----- sv/ptp_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for both lanes,
// which share the divisor. Depends on ptp_pkg.
module ptp_div
   import ptp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output div_type out_data,
   input  logic    out_ready
);

   div_type               st_ff [DIV_STAGES];
   div_type               st_in [DIV_STAGES];
   div_type               src   [DIV_STAGES];
   logic [DIV_STAGES-1:0] v_ff, v_in, src_v, rdy;

   // One restoring step per lane: shift in the next dividend bit and
   // subtract the divisor when the partial remainder reaches it.
   function automatic div_type div_step(input div_type d);
      logic [MAG_W:0] tx, ty, dx, dy;
      div_type        r;
      r  = d;
      tx = {d.rem_x, d.low_x[WORD_WIDTH-1]};
      ty = {d.rem_y, d.low_y[WORD_WIDTH-1]};
      dx = tx - {1'b0, d.ud};
      dy = ty - {1'b0, d.ud};
      if (tx >= {1'b0, d.ud}) begin
         r.rem_x = dx[MAG_W-1:0];
         r.q_x   = {d.q_x[WORD_WIDTH-2:0], 1'b1};
      end else begin
         r.rem_x = tx[MAG_W-1:0];
         r.q_x   = {d.q_x[WORD_WIDTH-2:0], 1'b0};
      end
      if (ty >= {1'b0, d.ud}) begin
         r.rem_y = dy[MAG_W-1:0];
         r.q_y   = {d.q_y[WORD_WIDTH-2:0], 1'b1};
      end else begin
         r.rem_y = ty[MAG_W-1:0];
         r.q_y   = {d.q_y[WORD_WIDTH-2:0], 1'b0};
      end
      r.low_x = {d.low_x[WORD_WIDTH-2:0], 1'b0};
      r.low_y = {d.low_y[WORD_WIDTH-2:0], 1'b0};
      return r;
   endfunction

   // Ready runs back from the output, so bubbles close up under a stall.
   always_comb begin
      rdy[DIV_STAGES-1] = !v_ff[DIV_STAGES-1] || out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   // Each stage is fed by the one before it, the first by the input.
   always_comb begin
      src[0]   = in_data;
      src_v[0] = in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
         src[k]   = st_ff[k-1];
         src_v[k] = v_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         v_in[k]  = rdy[k] ? src_v[k] : v_ff[k];
         st_in[k] = (rdy[k] && src_v[k]) ? div_step(src[k]) : st_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];

endmodule

// ----- sv/ptp_fin.sv -----
// Output section: saturation, sign, zero-w override and status, held in
// the result register. Depends on ptp_pkg.
module ptp_fin
   import ptp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  div_type           in_data,
   output logic              in_ready,
   output logic              out_valid,
   output logic [PORT_W-1:0] out_x,
   output logic [PORT_W-1:0] out_y,
   output status_type        out_status,
   input  logic              out_ready
);

   logic                  v_ff, v_in, rdy;
   logic [PORT_W-1:0]     x_ff, x_in, y_ff, y_in;
   status_type            st_ff, st_in;
   logic [WORD_WIDTH-1:0] lim_x, lim_y, qs_x, qs_y, res_x, res_y;
   logic                  sat_x, sat_y;

   assign rdy      = !v_ff || out_ready;
   assign in_ready = rdy;

   // Clamp each magnitude to the signed range, then restore the sign.
   always_comb begin
      lim_x = in_data.neg_x ? HALF_WORD : HALF_WORD - 1'b1;
      lim_y = in_data.neg_y ? HALF_WORD : HALF_WORD - 1'b1;
      sat_x = in_data.ovf_x || (in_data.q_x > lim_x);
      sat_y = in_data.ovf_y || (in_data.q_y > lim_y);
      qs_x  = sat_x ? lim_x : in_data.q_x;
      qs_y  = sat_y ? lim_y : in_data.q_y;
      res_x = in_data.neg_x ? -qs_x : qs_x;
      res_y = in_data.neg_y ? -qs_y : qs_y;
   end

   // A zero w overrides everything with zero results.
   always_comb begin
      v_in  = rdy ? in_valid : v_ff;
      x_in  = x_ff;
      y_in  = y_ff;
      st_in = st_ff;
      if (rdy && in_valid) begin
         if (in_data.zero) begin
            x_in  = '0;
            y_in  = '0;
            st_in = ST_ZERO;
         end else begin
            x_in  = PORT_W'(signed'(res_x));
            y_in  = PORT_W'(signed'(res_y));
            st_in = (sat_x || sat_y) ? ST_SAT : ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      y_ff  <= y_in;
      st_ff <= st_in;
   end

   assign out_valid  = v_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_status = st_ff;

endmodule

// ----- tb/ptp_projection_checker.sv -----
// Checker for the perspective point transform: follows the register writes,
// predicts the projected point of every accepted word and compares results.
// Depends on ptp_pkg.
module ptp_projection_checker
   import ptp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [PORT_W-1:0]    req_point_x,
   input  logic [PORT_W-1:0]    req_point_y,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [PORT_W-1:0]    rsp_proj_x,
   input  logic [PORT_W-1:0]    rsp_proj_y,
   input  logic [1:0]           rsp_status,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   output int                   error_total,
   output int                   points_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [WORD_WIDTH-1:0] fx_word_type;

   typedef struct packed {
      logic [PORT_W-1:0] proj_x;
      logic [PORT_W-1:0] proj_y;
      status_type        status;
   } proj_word_type;

   // Local copy of the matrix registers.
   logic [CSR_W-1:0]  row0_reg;
   logic [CSR_W-1:0]  row1_reg;
   logic [CSR_W-1:0]  row3_reg;
   logic [CSR_W-1:0]  xyoff_reg;
   logic [PORT_W-1:0] woff_reg;

   proj_word_type expected_proj[$];
   proj_word_type want;

   initial begin
      error_total = 0;
      points_in_flight = 0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report(input string what);
      error_total++;
      $display("ptp checker: %s", what);
   endtask

   // Fixed-point product, shifted down with rounding toward minus infinity.
   function automatic logic signed [63:0] scaled_product(input fx_word_type a,
                                                         input fx_word_type b);
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      logic signed [63:0] prod;
      wide_a = a;
      wide_b = b;
      prod = wide_a * wide_b;
      return prod >>> FRAC_BITS;
   endfunction

   // Quotient num * 2^FRAC_BITS / den, truncated toward zero and clipped to the
   // word range; den is never zero here.
   function automatic logic [PORT_W-1:0] scaled_quotient(input logic signed [63:0] num,
                                                         input logic signed [63:0] den,
                                                         output bit clipped);
      logic signed [127:0]      wide_num;
      logic signed [127:0]      quo;
      logic signed [127:0]      top_lim;
      logic signed [127:0]      bot_lim;
      fx_word_type              narrow;
      logic signed [PORT_W-1:0] ext;
      wide_num = num;
      wide_num = wide_num <<< FRAC_BITS;
      quo = wide_num / den;
      top_lim = (128'sd1 <<< (WORD_WIDTH - 1)) - 128'sd1;
      bot_lim = -(128'sd1 <<< (WORD_WIDTH - 1));
      clipped = 1'b0;
      if (quo > top_lim) begin
         quo = top_lim;
         clipped = 1'b1;
      end else if (quo < bot_lim) begin
         quo = bot_lim;
         clipped = 1'b1;
      end
      narrow = quo[WORD_WIDTH-1:0];
      ext = narrow;
      return ext;
   endfunction

   // Transform one point through rows 0, 1 and 3 and divide by w.
   function automatic proj_word_type project_point(input logic [PORT_W-1:0] px,
                                                   input logic [PORT_W-1:0] py);
      fx_word_type        x;
      fx_word_type        y;
      logic signed [63:0] nx;
      logic signed [63:0] ny;
      logic signed [63:0] w;
      bit                 clip_x;
      bit                 clip_y;
      proj_word_type      res;
      x = px[WORD_WIDTH-1:0];
      y = py[WORD_WIDTH-1:0];
      nx = scaled_product(fx_word_type'(row0_reg[32 +: WORD_WIDTH]), x)
         + scaled_product(fx_word_type'(row0_reg[0 +: WORD_WIDTH]), y)
         + fx_word_type'(xyoff_reg[32 +: WORD_WIDTH]);
      ny = scaled_product(fx_word_type'(row1_reg[32 +: WORD_WIDTH]), x)
         + scaled_product(fx_word_type'(row1_reg[0 +: WORD_WIDTH]), y)
         + fx_word_type'(xyoff_reg[0 +: WORD_WIDTH]);
      w = scaled_product(fx_word_type'(row3_reg[32 +: WORD_WIDTH]), x)
        + scaled_product(fx_word_type'(row3_reg[0 +: WORD_WIDTH]), y)
        + fx_word_type'(woff_reg[0 +: WORD_WIDTH]);
      if (w == 0) begin
         res.proj_x = '0;
         res.proj_y = '0;
         res.status = ST_ZERO;
      end else begin
         res.proj_x = scaled_quotient(nx, w, clip_x);
         res.proj_y = scaled_quotient(ny, w, clip_y);
         res.status = (clip_x || clip_y) ? ST_SAT : ST_OK;
      end
      return res;
   endfunction

   // Watch the three channels; all values are sampled as they stood before the edge.
   always @(posedge clock) begin
      if (reset) begin
         expected_proj.delete();
         row0_reg  <= ROW0_RESET;
         row1_reg  <= ROW1_RESET;
         row3_reg  <= ROW3_RESET;
         xyoff_reg <= XYOFF_RESET;
         woff_reg  <= WOFF_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_ROW0:  row0_reg  <= csr_data;
               REG_ROW1:  row1_reg  <= csr_data;
               REG_ROW3:  row3_reg  <= csr_data;
               REG_XYOFF: xyoff_reg <= csr_data;
               REG_WOFF:  woff_reg  <= csr_data[PORT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_proj.push_back(project_point(req_point_x, req_point_y));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_proj.size() == 0) begin
               report($sformatf("result x=%h y=%h status=%0d with nothing expected",
                                rsp_proj_x, rsp_proj_y, rsp_status));
            end else begin
               want = expected_proj.pop_front();
               if (rsp_proj_x !== want.proj_x) begin
                  report($sformatf("proj_x %h, expected %h", rsp_proj_x, want.proj_x));
               end
               if (rsp_proj_y !== want.proj_y) begin
                  report($sformatf("proj_y %h, expected %h", rsp_proj_y, want.proj_y));
               end
               if (rsp_status !== want.status) begin
                  report($sformatf("status %0d, expected %0d", rsp_status, want.status));
               end
            end
         end
      end
      points_in_flight = expected_proj.size();
   end

endmodule

// ----- tb/point_transform_perspective_core_test.sv -----
// Top of the perspective point transform testbench: clock, reset, stimulus
// and verdict. Depends on ptp_pkg, point_transform_perspective_core and
// ptp_projection_checker.
module point_transform_perspective_core_test
   import ptp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles to let the pipeline empty before a register write or the verdict.
   localparam int SETTLE_CYCLES = WORD_WIDTH + 13;
   localparam int ITEMS_PER_SETTING = 96;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PORT_W-1:0]    req_point_x = '0;
   logic [PORT_W-1:0]    req_point_y = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PORT_W-1:0]    rsp_proj_x;
   logic [PORT_W-1:0]    rsp_proj_y;
   logic [1:0]           rsp_status;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_data = '0;
   int                   error_total;
   int                   points_in_flight;

   int send_gap_pct = 0;
   int rsp_stall_pct = 0;

   point_transform_perspective_core DUT (.*);

   ptp_projection_checker checker_inst (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("point_transform_perspective_core: mismatch");
      $finish;
   end

   // Random signed value of the given width, sign-extended to 32 bits.
   function automatic logic [31:0] spread(input int bits);
      logic signed [31:0] r;
      r = $urandom;
      r = r <<< (32 - bits);
      return r >>> (32 - bits);
   endfunction

   // One of the edge values of a Q16.16 word.
   function automatic logic [31:0] pick_edge();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'h0001_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   // Mostly moderate coordinates, some full-range and some edge values.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: return pick_edge();
         default: return spread(24);
      endcase
   endfunction

   // Offer one word, after a random idle stretch, and hold it until taken.
   task automatic push_point(input logic [PORT_W-1:0] x, input logic [PORT_W-1:0] y);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic settle_block();
      req_valid <= 1'b0;
      do @(negedge clock); while (points_in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the caller lowers csr_valid after the last one.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load a full matrix setting with the block idle, optionally followed by
   // a write to an index that does not exist.
   task automatic apply_setting(input logic [CSR_W-1:0] r0, input logic [CSR_W-1:0] r1,
                                input logic [CSR_W-1:0] r3, input logic [CSR_W-1:0] xo,
                                input logic [PORT_W-1:0] wo, input bit stray);
      settle_block();
      write_csr(REG_ROW0, r0);
      write_csr(REG_ROW1, r1);
      write_csr(REG_ROW3, r3);
      write_csr(REG_XYOFF, xo);
      write_csr(REG_WOFF, {$urandom, wo});
      if (stray) begin
         write_csr(CSR_IDX_W'(int'(REG_WOFF) + 1 + $urandom_range(2)), {$urandom, $urandom});
      end
      csr_valid <= 1'b0;
   endtask

   // Pick a random kind of matrix: affine, mild perspective, wild, edge or zero w.
   task automatic random_setting();
      logic [CSR_W-1:0]  r0;
      logic [CSR_W-1:0]  r1;
      logic [CSR_W-1:0]  r3;
      logic [CSR_W-1:0]  xo;
      logic [PORT_W-1:0] wo;
      r0 = {spread(20), spread(20)};
      r1 = {spread(20), spread(20)};
      xo = {spread(24), spread(24)};
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            r3 = '0;
            wo = ($urandom_range(1) == 0) ? 32'h0001_0000 : spread(20);
         end
         4, 5, 6: begin
            r3 = {spread(12), spread(12)};
            wo = 32'h0001_0000 + spread(16);
         end
         7: begin
            r0 = {$urandom, $urandom};
            r1 = {$urandom, $urandom};
            r3 = {$urandom, $urandom};
            xo = {$urandom, $urandom};
            wo = $urandom;
         end
         8: begin
            r0 = {pick_edge(), pick_edge()};
            r1 = {pick_edge(), pick_edge()};
            r3 = {pick_edge(), pick_edge()};
            xo = {pick_edge(), pick_edge()};
            wo = pick_edge();
         end
         default: begin
            r3 = '0;
            wo = '0;
         end
      endcase
      apply_setting(r0, r1, r3, xo, wo, $urandom_range(2) == 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity matrix after reset: zero, extremes and unit values.
      push_point(32'h0000_0000, 32'h0000_0000);
      push_point(32'h7fff_ffff, 32'h8000_0000);
      push_point(32'h8000_0000, 32'h7fff_ffff);
      push_point(32'h0001_0000, 32'hffff_0000);
      push_point(32'hffff_ffff, 32'h0000_0001);

      // Constant w of zero gives zero results with the zero status.
      apply_setting(ROW0_RESET, ROW1_RESET, ROW3_RESET, XYOFF_RESET, 32'h0, 1'b1);
      push_point(32'h1234_5678, 32'h9abc_def0);

      // Tiny w pushes the quotients out of range in both directions.
      apply_setting(ROW0_RESET, ROW1_RESET, ROW3_RESET, XYOFF_RESET, 32'h1, 1'b0);
      push_point(32'h0001_0000, 32'h0000_0000);
      push_point(32'h0000_0000, 32'h0000_0000);
      push_point(32'hffff_0000, 32'h0000_0001);

      // Negative w with offsets at the ends of the range.
      apply_setting(ROW0_RESET, ROW1_RESET, ROW3_RESET, 64'h7fff_ffff_8000_0000,
                    32'hffff_0000, 1'b0);
      push_point(32'h0000_0000, 32'h0000_0000);
      push_point(32'h0001_0000, 32'h0001_0000);

      // w taken from the point itself, cancelling to zero for one of them.
      apply_setting(ROW0_RESET, ROW1_RESET, 64'h0001_0000_0001_0000, XYOFF_RESET,
                    32'h0, 1'b1);
      push_point(32'h0001_0000, 32'hffff_0000);
      push_point(32'h0002_0000, 32'h0001_0000);
      push_point(32'hffff_ffff, 32'hffff_ffff);

      // Coefficients at the most negative value (w offset at the largest), then the reverse.
      apply_setting(64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                    64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 32'h7fff_ffff, 1'b0);
      push_point(32'h8000_0000, 32'h8000_0000);
      push_point(32'h7fff_ffff, 32'h7fff_ffff);
      push_point(32'hffff_ffff, 32'h0000_0000);
      apply_setting(64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff,
                    64'h7fff_ffff_7fff_ffff, 64'h7fff_ffff_7fff_ffff, 32'h8000_0000, 1'b1);
      push_point(32'h8000_0000, 32'h7fff_ffff);
      push_point(32'h0000_0001, 32'hffff_ffff);

      // Random part: four idling modes, several matrices each.
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               send_gap_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_gap_pct = 49;
               rsp_stall_pct = 0;
            end
            2: begin
               send_gap_pct = 0;
               rsp_stall_pct = 49;
            end
            default: begin
               send_gap_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         for (int s = 0; s < 3; s++) begin
            random_setting();
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
               // Now and then let the whole pipeline run dry mid-stream.
               if ($urandom_range(199) == 0) begin
                  settle_block();
               end
               push_point(pick_coord(), pick_coord());
            end
         end
      end

      settle_block();
      @(negedge clock);
      if (error_total == 0) begin
         $display("point_transform_perspective_core: match");
      end else begin
         $display("point_transform_perspective_core: mismatch");
      end
      $finish;
   end

endmodule
